// File: sv/spc_pkg.sv
// Shared types and constants for the Sznajd pair conversion step.
// Holds field widths, operation and status codes, and the command and status
// structs that join the controller to the datapath. Depends on nothing.
package spc_pkg;

	localparam int OP_W     = 2;
	localparam int NODE_W   = 10;
	localparam int SLOT_W   = 4;
	localparam int VALUE_W  = 10;
	localparam int ACTIVE_W = 11;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 11;
	localparam int CONV_W   = 6;

	typedef enum logic [OP_W-1:0] {
		OP_SET_OPINION   = 2'd0,
		OP_SET_DEGREE    = 2'd1,
		OP_SET_NEIGHBOUR = 2'd2,
		OP_INTERACT      = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_LOAD_DONE = 2'd0,
		ST_CONVERTED = 2'd1,
		ST_DISAGREED = 2'd2,
		ST_REJECTED  = 2'd3
	} status_t;

	typedef struct packed {
		logic    capture;
		logic    clr_wr;
		logic    load_opinion;
		logic    wr_degree;
		logic    wr_table;
		logic    rd_pair;
		logic    latch_degb;
		logic    start_a;
		logic    start_b;
		logic    rd_tab;
		logic    rd_op;
		logic    conv_wr;
		logic    next_ent;
		logic    set_status;
		status_t status;
		logic    load_out;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic node_ok;
		logic degree_ok;
		logic entry_ok;
		logic slot_ok;
		logic tab_ok;
		logic agree;
		logic ent_more;
		logic sel_b;
		logic out_free;
		logic clr_last;
	} stat_t;

endpackage

// File: sv/spc_in_if.sv
// Input channel of the Sznajd pair conversion step: valid, ready and one item.
// Depends on spc_pkg for the field widths.
interface spc_in_if import spc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [NODE_W-1:0]  node;
	logic [SLOT_W-1:0]  slot;
	logic [VALUE_W-1:0] value;

	modport source (output valid, operation, node, slot, value, input ready);
	modport sink (input valid, operation, node, slot, value, output ready);
endinterface

// File: sv/spc_out_if.sv
// Result channel of the Sznajd pair conversion step: valid, ready and one item.
// Depends on spc_pkg for the field widths.
interface spc_out_if import spc_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  count_a;
	logic [COUNT_W-1:0]  count_b;
	logic [CONV_W-1:0]   converted;
	logic                consensus;

	modport source (output valid, status, count_a, count_b, converted, consensus, input ready);
	modport sink (input valid, status, count_a, count_b, converted, consensus, output ready);
endinterface

// File: sv/spc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module spc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/spc_ctrl.sv
// Controller state machine of the Sznajd pair conversion step.
// Depends on spc_pkg; drives the datapath through cmd_t and reads stat_t.
module spc_ctrl import spc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  stat_t stat,
	output logic  in_ready,
	output cmd_t  cmd
);

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_CHECK = 9'b000000100,
		S_READ1 = 9'b000001000,
		S_READ2 = 9'b000010000,
		S_TAB   = 9'b000100000,
		S_OPR   = 9'b001000000,
		S_OPW   = 9'b010000000,
		S_EMIT  = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nx    = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!stat.node_ok) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_REJECTED;
					state_nx       = S_EMIT;
				end else begin
					case (stat.op)
						OP_SET_DEGREE: begin
							cmd.set_status = 1'b1;
							cmd.wr_degree  = stat.degree_ok;
							cmd.status     = stat.degree_ok ? ST_LOAD_DONE : ST_REJECTED;
							state_nx       = S_EMIT;
						end
						OP_SET_NEIGHBOUR: begin
							cmd.set_status = 1'b1;
							cmd.wr_table   = stat.entry_ok;
							cmd.status     = stat.entry_ok ? ST_LOAD_DONE : ST_REJECTED;
							state_nx       = S_EMIT;
						end
						default: begin
							state_nx = S_READ1;
						end
					endcase
				end
			end
			S_READ1: begin
				if (stat.op == OP_SET_OPINION) begin
					cmd.load_opinion = 1'b1;
					cmd.set_status   = 1'b1;
					cmd.status       = ST_LOAD_DONE;
					state_nx         = S_EMIT;
				end else if (!stat.slot_ok || !stat.tab_ok) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_REJECTED;
					state_nx       = S_EMIT;
				end else begin
					cmd.rd_pair = 1'b1;
					state_nx    = S_READ2;
				end
			end
			S_READ2: begin
				if (!stat.agree) begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_DISAGREED;
					state_nx       = S_EMIT;
				end else begin
					cmd.latch_degb = 1'b1;
					cmd.start_a    = 1'b1;
					state_nx       = S_TAB;
				end
			end
			S_TAB: begin
				if (stat.ent_more) begin
					cmd.rd_tab = 1'b1;
					state_nx   = S_OPR;
				end else if (!stat.sel_b) begin
					cmd.start_b = 1'b1;
				end else begin
					cmd.set_status = 1'b1;
					cmd.status     = ST_CONVERTED;
					state_nx       = S_EMIT;
				end
			end
			S_OPR: begin
				if (stat.tab_ok) begin
					cmd.rd_op = 1'b1;
					state_nx  = S_OPW;
				end else begin
					cmd.next_ent = 1'b1;
					state_nx     = S_TAB;
				end
			end
			S_OPW: begin
				cmd.conv_wr  = 1'b1;
				cmd.next_ent = 1'b1;
				state_nx     = S_TAB;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_CLEAR;
			end
		endcase
	end

endmodule

// File: sv/spc_datapath.sv
// Datapath of the Sznajd pair conversion step: stores, counters and result register.
// Depends on spc_pkg, spc_ram and spc_out_if; obeys cmd_t from spc_ctrl.
module spc_datapath import spc_pkg::*; #(
	parameter int NODES      = 1024,
	parameter int MAX_DEGREE = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [ACTIVE_W-1:0] cfg_wdata,
	input  logic [OP_W-1:0]     in_operation,
	input  logic [NODE_W-1:0]   in_node,
	input  logic [SLOT_W-1:0]   in_slot,
	input  logic [VALUE_W-1:0]  in_value,
	input  cmd_t                cmd,
	output stat_t               stat,
	spc_out_if.source           res
);

	localparam int AW    = $clog2(NODES);
	localparam int ACT_W = $clog2(NODES + 1);
	localparam int DW    = $clog2(MAX_DEGREE + 1);
	localparam int TD    = NODES * MAX_DEGREE;
	localparam int TAW   = $clog2(TD);

	logic [ACT_W-1:0]   active_q;
	logic [ACT_W-1:0]   count_q;
	logic [CONV_W-1:0]  flip_q;
	op_t                op_q;
	logic [NODE_W-1:0]  node_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [VALUE_W-1:0] value_q;
	logic               pair_op_q;
	logic [VALUE_W-1:0] nb_q;
	logic [VALUE_W-1:0] t_q;
	logic [DW-1:0]      deg_a_q;
	logic [DW-1:0]      deg_b_q;
	logic               sel_b_q;
	logic [DW-1:0]      i_q;
	logic [AW-1:0]      clr_q;
	status_t            status_q;
	logic               out_valid_q;

	logic [31:0]        cfg_clamped;
	logic [31:0]        item_tab_full;
	logic [31:0]        agent_tab_full;
	logic [DW-1:0]      deg_sel;
	logic [ACT_W-1:0]   b_full;

	logic               op_we;
	logic [AW-1:0]      op_waddr;
	logic               op_wdata;
	logic [AW-1:0]      op_raddr;
	logic               op_rd;
	logic               deg_we;
	logic [AW-1:0]      deg_waddr;
	logic [DW-1:0]      deg_wdata;
	logic [AW-1:0]      deg_raddr;
	logic [DW-1:0]      deg_rd;
	logic [TAW-1:0]     tab_raddr;
	logic [VALUE_W-1:0] tab_rd;

	assign item_tab_full  = 32'(node_q) * 32'(MAX_DEGREE) + 32'(slot_q);
	assign agent_tab_full = (sel_b_q ? 32'(nb_q) : 32'(node_q)) * 32'(MAX_DEGREE) + 32'(i_q);
	assign deg_sel        = sel_b_q ? deg_b_q : deg_a_q;
	assign b_full         = (active_q > count_q) ? (active_q - count_q) : '0;

	always_comb begin
		cfg_clamped = 32'(cfg_wdata);
		if (cfg_clamped == 32'd0) begin
			cfg_clamped = 32'd1;
		end else if (cfg_clamped > 32'(NODES)) begin
			cfg_clamped = 32'(NODES);
		end
	end

	always_comb begin
		op_we    = 1'b0;
		op_waddr = AW'(node_q);
		op_wdata = 1'b0;
		if (cmd.clr_wr) begin
			op_we    = 1'b1;
			op_waddr = clr_q;
		end else if (cmd.load_opinion) begin
			op_we    = value_q[0] != op_rd;
			op_wdata = value_q[0];
		end else if (cmd.conv_wr) begin
			op_we    = op_rd != pair_op_q;
			op_waddr = AW'(t_q);
			op_wdata = pair_op_q;
		end
	end

	assign op_raddr  = (cmd.rd_pair || cmd.rd_op) ? AW'(tab_rd) : AW'(node_q);
	assign deg_we    = cmd.clr_wr || cmd.wr_degree;
	assign deg_waddr = cmd.clr_wr ? clr_q : AW'(node_q);
	assign deg_wdata = cmd.clr_wr ? '0 : DW'(value_q);
	assign deg_raddr = cmd.rd_pair ? AW'(tab_rd) : AW'(node_q);
	assign tab_raddr = cmd.rd_tab ? agent_tab_full[TAW-1:0] : item_tab_full[TAW-1:0];

	spc_ram #(.WIDTH(1), .DEPTH(NODES)) u_opinion (
		.clk  (clk),
		.we   (op_we),
		.waddr(op_waddr),
		.wdata(op_wdata),
		.raddr(op_raddr),
		.rdata(op_rd)
	);

	spc_ram #(.WIDTH(DW), .DEPTH(NODES)) u_degree (
		.clk  (clk),
		.we   (deg_we),
		.waddr(deg_waddr),
		.wdata(deg_wdata),
		.raddr(deg_raddr),
		.rdata(deg_rd)
	);

	spc_ram #(.WIDTH(VALUE_W), .DEPTH(TD)) u_table (
		.clk  (clk),
		.we   (cmd.wr_table),
		.waddr(item_tab_full[TAW-1:0]),
		.wdata(value_q),
		.raddr(tab_raddr),
		.rdata(tab_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= ACT_W'(NODES);
			count_q     <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				active_q <= cfg_clamped[ACT_W-1:0];
			end
			if (op_we && !cmd.clr_wr) begin
				if (op_wdata) begin
					count_q <= count_q + 1'b1;
				end else if (count_q != '0) begin
					count_q <= count_q - 1'b1;
				end
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op_t'(in_operation);
			node_q  <= in_node;
			slot_q  <= in_slot;
			value_q <= in_value;
			flip_q  <= '0;
		end else if (cmd.conv_wr && (op_rd != pair_op_q) && (flip_q != '1)) begin
			flip_q <= flip_q + 1'b1;
		end
		if (cmd.rd_pair) begin
			pair_op_q <= op_rd;
			deg_a_q   <= deg_rd;
			nb_q      <= tab_rd;
		end
		if (cmd.latch_degb) begin
			deg_b_q <= deg_rd;
		end
		if (cmd.start_a || cmd.start_b) begin
			sel_b_q <= cmd.start_b;
			i_q     <= '0;
		end else if (cmd.next_ent) begin
			i_q <= i_q + 1'b1;
		end
		if (cmd.rd_op) begin
			t_q <= tab_rd;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status;
		end
		if (cmd.load_out) begin
			res.status    <= status_q;
			res.count_a   <= COUNT_W'(count_q);
			res.count_b   <= COUNT_W'(b_full);
			res.converted <= flip_q;
			res.consensus <= (count_q == '0) || (b_full == '0);
		end
	end

	assign res.valid = out_valid_q;

	always_comb begin
		stat.op        = op_q;
		stat.node_ok   = (32'(node_q) < 32'(active_q)) && (32'(node_q) < 32'(NODES));
		stat.degree_ok = 32'(value_q) <= 32'(MAX_DEGREE);
		stat.entry_ok  = (32'(slot_q) < 32'(MAX_DEGREE)) && (32'(value_q) < 32'(active_q));
		stat.slot_ok   = (32'(slot_q) < 32'(deg_rd)) && (32'(slot_q) < 32'(MAX_DEGREE));
		stat.tab_ok    = (32'(tab_rd) < 32'(active_q)) && (32'(tab_rd) < 32'(NODES));
		stat.agree     = op_rd == pair_op_q;
		stat.ent_more  = (32'(i_q) < 32'(deg_sel)) && (32'(i_q) < 32'(MAX_DEGREE));
		stat.sel_b     = sel_b_q;
		stat.out_free  = !out_valid_q || res.ready;
		stat.clr_last  = clr_q == AW'(NODES - 1);
	end

endmodule

// File: sv/sznajd_pair_conversion_step.sv
// Top level of the Sznajd pair conversion step: controller, datapath and ports.
// Depends on spc_pkg, spc_in_if, spc_out_if, spc_ctrl and spc_datapath.
//
//   Port       Direction  Contents
//   item_in    sink       operation, node, slot, value
//   result_out source     status, count_a, count_b, converted, consensus
//   cfg_we     in         write strobe for active_nodes
//   cfg_wdata  in         active_nodes value, clamped to 1..NODES
//
// After reset a clearing pass zeroes every entry of the opinion and degree stores.
// A node out of range or a degree or neighbour load is settled in the check state, an
// opinion load or a bad slot in the first read state and a disagreeing pair in the second;
// a converting pair walks the neighbour lists of agent and neighbour in turn, skipping stale entries.
// The input is ready again the cycle after a result is loaded, one item in work at a time;
// a result waits in its output register and the block stalls only when a second one is due.
module sznajd_pair_conversion_step import spc_pkg::*; #(
	parameter int NODES      = 1024,
	parameter int MAX_DEGREE = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [ACTIVE_W-1:0] cfg_wdata,
	spc_in_if.sink              item_in,
	spc_out_if.source           result_out
);

	cmd_t  cmd;
	stat_t stat;
	logic  in_ready;

	assign item_in.ready = in_ready;

	spc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(item_in.valid),
		.stat    (stat),
		.in_ready(in_ready),
		.cmd     (cmd)
	);

	spc_datapath #(.NODES(NODES), .MAX_DEGREE(MAX_DEGREE)) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_operation(item_in.operation),
		.in_node     (item_in.node),
		.in_slot     (item_in.slot),
		.in_value    (item_in.value),
		.cmd         (cmd),
		.stat        (stat),
		.res         (result_out)
	);

endmodule
